// ===== design/cfpb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the contact friction block projection.
// The microcode program for the sweep sequencer lives here as a constant function.
// No dependencies.
package cfpb_pkg;

	localparam int FRAC_BITS = 24;
	localparam int Q_W = 48;
	localparam int ACC_W = Q_W + 3;
	localparam int PROD_W = 2 * Q_W;
	localparam int DIV_W = Q_W + FRAC_BITS;
	localparam int CNT_W = 7;
	localparam int PC_W = 7;
	localparam int EPS_LSB = ((1 << FRAC_BITS) + 500000) / 1000000;

	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] Q_ONE = ACC_W'(1) <<< FRAC_BITS;

	localparam logic [1:0] MODE_SMOOTH = 2'd1;
	localparam logic [1:0] MODE_ANISO = 2'd2;

	// Operand B codes above the store address range select configuration registers.
	localparam logic [5:0] B_KR = 6'd32;
	localparam logic [5:0] B_T2R = 6'd33;

	typedef enum logic [1:0] {
		CFG_MODE = 2'd0,
		CFG_VTHR = 2'd1,
		CFG_KR   = 2'd2,
		CFG_T2R  = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_CLR, OP_LDA, OP_MAC, OP_MSC, OP_ST, OP_DIVE, OP_DIVT, OP_MAX0,
		OP_SQ, OP_SQRT, OP_HERM, OP_ONEM, OP_CLAMP, OP_JMP, OP_DONE
	} uop_op_t;

	typedef enum logic [2:0] {
		C_ALWAYS, C_NOT_SMOOTH, C_NOT_ANISO, C_SPD_LO, C_SPD_HI
	} cond_t;

	typedef struct packed {
		uop_op_t op;
		logic [5:0] a;
		logic [5:0] b;
		cond_t cnd;
		logic [PC_W-1:0] tgt;
	} uop_t;

	typedef enum logic [1:0] {
		U_MUL, U_DIV, U_SQRT
	} unit_op_t;

	typedef struct packed {
		logic start;
		unit_op_t op;
	} ureq_t;

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH_A, S_FETCH_B, S_EXEC, S_WAIT, S_OUT
	} state_t;

	localparam int L_SMCHK = 14;
	localparam int L_KINSEL = 50;
	localparam int L_MUST = 51;
	localparam int L_LIMITS = 53;

	function automatic uop_t mk(input uop_op_t op, input int a, input int b,
		input cond_t c, input int t);
		return '{op: op, a: 6'(a), b: 6'(b), cnd: c, tgt: PC_W'(t)};
	endfunction

	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			7'd0: u = mk(OP_LDA, 9, 0, C_ALWAYS, 0);
			7'd1: u = mk(OP_MSC, 1, 12, C_ALWAYS, 0);
			7'd2: u = mk(OP_MSC, 2, 13, C_ALWAYS, 0);
			7'd3: u = mk(OP_ST, 24, 0, C_ALWAYS, 0);
			7'd4: u = mk(OP_DIVE, 24, 0, C_ALWAYS, 0);
			7'd5: u = mk(OP_MAX0, 0, 0, C_ALWAYS, 0);
			7'd6: u = mk(OP_ST, 24, 0, C_ALWAYS, 0);
			7'd7: u = mk(OP_LDA, 14, 0, C_ALWAYS, 0);
			7'd8: u = mk(OP_ST, 25, 0, C_ALWAYS, 0);
			7'd9: u = mk(OP_ST, 26, 0, C_ALWAYS, 0);
			7'd10: u = mk(OP_JMP, 0, 0, C_NOT_ANISO, L_SMCHK);
			7'd11: u = mk(OP_CLR, 0, 0, C_ALWAYS, 0);
			7'd12: u = mk(OP_MAC, 14, int'(B_T2R), C_ALWAYS, 0);
			7'd13: u = mk(OP_ST, 26, 0, C_ALWAYS, 0);
			7'd14: u = mk(OP_JMP, 0, 0, C_NOT_SMOOTH, L_LIMITS);
			7'd15: u = mk(OP_CLR, 0, 0, C_ALWAYS, 0);
			7'd16: u = mk(OP_MAC, 14, int'(B_KR), C_ALWAYS, 0);
			7'd17: u = mk(OP_ST, 27, 0, C_ALWAYS, 0);
			7'd18: u = mk(OP_CLR, 0, 0, C_ALWAYS, 0);
			7'd19: u = mk(OP_MAC, 15, 18, C_ALWAYS, 0);
			7'd20: u = mk(OP_MAC, 16, 19, C_ALWAYS, 0);
			7'd21: u = mk(OP_MAC, 17, 20, C_ALWAYS, 0);
			7'd22: u = mk(OP_ST, 28, 0, C_ALWAYS, 0);
			7'd23: u = mk(OP_CLR, 0, 0, C_ALWAYS, 0);
			7'd24: u = mk(OP_MAC, 15, 21, C_ALWAYS, 0);
			7'd25: u = mk(OP_MAC, 16, 22, C_ALWAYS, 0);
			7'd26: u = mk(OP_MAC, 17, 23, C_ALWAYS, 0);
			7'd27: u = mk(OP_ST, 29, 0, C_ALWAYS, 0);
			7'd28: u = mk(OP_SQ, 28, 0, C_ALWAYS, 0);
			7'd29: u = mk(OP_SQ, 29, 0, C_ALWAYS, 0);
			7'd30: u = mk(OP_SQRT, 0, 0, C_ALWAYS, 0);
			7'd31: u = mk(OP_ST, 28, 0, C_ALWAYS, 0);
			7'd32: u = mk(OP_JMP, 0, 0, C_SPD_LO, L_LIMITS);
			7'd33: u = mk(OP_JMP, 0, 0, C_SPD_HI, L_KINSEL);
			7'd34: u = mk(OP_DIVT, 28, 0, C_ALWAYS, 0);
			7'd35: u = mk(OP_ST, 29, 0, C_ALWAYS, 0);
			7'd36: u = mk(OP_CLR, 0, 0, C_ALWAYS, 0);
			7'd37: u = mk(OP_MAC, 29, 29, C_ALWAYS, 0);
			7'd38: u = mk(OP_ST, 30, 0, C_ALWAYS, 0);
			7'd39: u = mk(OP_CLR, 0, 0, C_ALWAYS, 0);
			7'd40: u = mk(OP_MAC, 30, 29, C_ALWAYS, 0);
			7'd41: u = mk(OP_ST, 31, 0, C_ALWAYS, 0);
			7'd42: u = mk(OP_HERM, 30, 31, C_ALWAYS, 0);
			7'd43: u = mk(OP_ST, 29, 0, C_ALWAYS, 0);
			7'd44: u = mk(OP_ONEM, 29, 0, C_ALWAYS, 0);
			7'd45: u = mk(OP_ST, 30, 0, C_ALWAYS, 0);
			7'd46: u = mk(OP_CLR, 0, 0, C_ALWAYS, 0);
			7'd47: u = mk(OP_MAC, 14, 30, C_ALWAYS, 0);
			7'd48: u = mk(OP_MAC, 27, 29, C_ALWAYS, 0);
			7'd49: u = mk(OP_JMP, 0, 0, C_ALWAYS, L_MUST);
			7'd50: u = mk(OP_LDA, 27, 0, C_ALWAYS, 0);
			7'd51: u = mk(OP_ST, 25, 0, C_ALWAYS, 0);
			7'd52: u = mk(OP_ST, 26, 0, C_ALWAYS, 0);
			7'd53: u = mk(OP_CLR, 0, 0, C_ALWAYS, 0);
			7'd54: u = mk(OP_MAC, 25, 24, C_ALWAYS, 0);
			7'd55: u = mk(OP_ST, 25, 0, C_ALWAYS, 0);
			7'd56: u = mk(OP_CLR, 0, 0, C_ALWAYS, 0);
			7'd57: u = mk(OP_MAC, 26, 24, C_ALWAYS, 0);
			7'd58: u = mk(OP_ST, 26, 0, C_ALWAYS, 0);
			7'd59: u = mk(OP_LDA, 10, 0, C_ALWAYS, 0);
			7'd60: u = mk(OP_MSC, 3, 24, C_ALWAYS, 0);
			7'd61: u = mk(OP_MSC, 5, 13, C_ALWAYS, 0);
			7'd62: u = mk(OP_ST, 28, 0, C_ALWAYS, 0);
			7'd63: u = mk(OP_DIVE, 28, 4, C_ALWAYS, 0);
			7'd64: u = mk(OP_CLAMP, 25, 0, C_ALWAYS, 0);
			7'd65: u = mk(OP_ST, 12, 0, C_ALWAYS, 0);
			7'd66: u = mk(OP_LDA, 11, 0, C_ALWAYS, 0);
			7'd67: u = mk(OP_MSC, 6, 24, C_ALWAYS, 0);
			7'd68: u = mk(OP_MSC, 7, 12, C_ALWAYS, 0);
			7'd69: u = mk(OP_ST, 28, 0, C_ALWAYS, 0);
			7'd70: u = mk(OP_DIVE, 28, 8, C_ALWAYS, 0);
			7'd71: u = mk(OP_CLAMP, 26, 0, C_ALWAYS, 0);
			7'd72: u = mk(OP_ST, 13, 0, C_ALWAYS, 0);
			default: u = mk(OP_DONE, 0, 0, C_ALWAYS, 0);
		endcase
		return u;
	endfunction

	function automatic logic [Q_W-1:0] mag48(input logic signed [Q_W-1:0] v);
		return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
	endfunction

	function automatic logic [Q_W:0] mag49(input logic signed [Q_W:0] v);
		return v[Q_W] ? (Q_W+1)'(-v) : (Q_W+1)'(v);
	endfunction

	function automatic logic signed [Q_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > ACC_W'(Q_MAX))
			r = Q_MAX;
		else if (v < ACC_W'(Q_MIN))
			r = Q_MIN;
		else
			r = v[Q_W-1:0];
		return r;
	endfunction

	function automatic logic signed [Q_W-1:0] sat_mag(input logic neg,
		input logic [PROD_W-1:0] m);
		logic signed [Q_W-1:0] r;
		if (neg) begin
			if (m > (PROD_W'(1) << (Q_W-1)))
				r = Q_MIN;
			else
				r = -$signed(m[Q_W-1:0]);
		end else begin
			if (m > PROD_W'(Q_MAX))
				r = Q_MAX;
			else
				r = $signed(m[Q_W-1:0]);
		end
		return r;
	endfunction

endpackage

// ===== design/contact_friction_block_projection.sv =====
// Top level: operand store, microcoded sweep sequencer and stream ports.
// Depends on cfpb_pkg and cfpb_unit.
//
// Operands are loaded one per cycle, while the block is idle, into a 32-entry store (24
// operand slots and eight scratch slots). The transaction marked tlast starts one
// projected Gauss-Seidel sweep, during which the input stays not ready. The sweep is a
// microcode program driving one bit-serial unit for each multiply, divide and the square
// root; each micro-operation also passes through the store access states fetch A and B.
// The result sits in an output register, so loading of the next contact may begin while
// it waits to be taken.
module contact_friction_block_projection (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// element_index [4:0], element_value [52:5], zero pad
	input  logic [55:0]   s_axis_tdata,
	input  logic          s_axis_tlast,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// normal_impulse [47:0], tangent1_impulse [95:48], tangent2_impulse [143:96]
	output logic [143:0]  m_axis_tdata,
	// divide_fault [0]
	output logic [0:0]    m_axis_tuser,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [46:0]   cfg_data
);

	localparam int QW = cfpb_pkg::Q_W;
	localparam int AW = cfpb_pkg::ACC_W;

	cfpb_pkg::state_t state_q, state_d;
	logic [cfpb_pkg::PC_W-1:0] pc_q, pc_next;
	cfpb_pkg::uop_t uop;

	logic [1:0] mode_q;
	logic [46:0] vthr_q;
	logic [25:0] kr_q;
	logic [25:0] t2r_q;

	logic [QW-1:0] mem [32];
	logic [4:0] raddr;
	logic [QW-1:0] rdata_q;
	logic we;
	logic [4:0] waddr;
	logic [QW-1:0] wdata;

	logic signed [QW-1:0] opa_q;
	logic signed [QW-1:0] opb;
	logic signed [AW-1:0] sa, sb;
	logic signed [AW-1:0] acc_q;
	logic [cfpb_pkg::PROD_W-1:0] sq_q;
	logic neg_q, neg_d;
	logic spd_lo_q, spd_hi_q, fault_q;
	logic signed [QW-1:0] l0_q, l1_q, l2_q;
	logic m_valid_q;

	logic s_acc, last_acc, out_free;
	logic signed [QW:0] den;
	logic den_zero;
	logic use_unit;
	logic jmp_taken;
	cfpb_pkg::ureq_t ureq;
	logic [cfpb_pkg::PROD_W-1:0] src_a;
	logic [QW:0] src_b;
	logic udone;
	logic [cfpb_pkg::PROD_W-1:0] ures;
	logic signed [QW-1:0] qres;
	logic signed [QW-1:0] st_val;
	logic signed [AW-1:0] lo_b, cmin;

	assign uop = cfpb_pkg::ucode(pc_q);
	assign s_axis_tready = (state_q == cfpb_pkg::S_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign last_acc = s_acc && s_axis_tlast;
	assign out_free = !m_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			vthr_q <= 47'd16777216;
			kr_q <= 26'd16777216;
			t2r_q <= 26'd16777216;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cfpb_pkg::CFG_MODE: mode_q <= cfg_data[1:0];
				cfpb_pkg::CFG_VTHR: vthr_q <= cfg_data;
				cfpb_pkg::CFG_KR: kr_q <= cfg_data[25:0];
				cfpb_pkg::CFG_T2R: t2r_q <= cfg_data[25:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sa = {{(AW-QW){opa_q[QW-1]}}, opa_q};
		if (uop.b == cfpb_pkg::B_KR)
			opb = QW'(kr_q);
		else if (uop.b == cfpb_pkg::B_T2R)
			opb = QW'(t2r_q);
		else
			opb = rdata_q;
		sb = {{(AW-QW){opb[QW-1]}}, opb};
		den = {opb[QW-1], opb} + (QW+1)'(cfpb_pkg::EPS_LSB);
		den_zero = (den == '0);
		st_val = cfpb_pkg::sat_acc(acc_q);
		lo_b = {{(AW-QW){1'b0}}, {QW{1'b0}}};
		lo_b = AW'(cfpb_pkg::sat_acc(-sa));
		cmin = (acc_q < sa) ? acc_q : sa;
		unique case (uop.cnd)
			cfpb_pkg::C_ALWAYS: jmp_taken = 1'b1;
			cfpb_pkg::C_NOT_SMOOTH: jmp_taken = (mode_q != cfpb_pkg::MODE_SMOOTH);
			cfpb_pkg::C_NOT_ANISO: jmp_taken = (mode_q != cfpb_pkg::MODE_ANISO);
			cfpb_pkg::C_SPD_LO: jmp_taken = spd_lo_q;
			cfpb_pkg::C_SPD_HI: jmp_taken = spd_hi_q;
			default: jmp_taken = 1'b0;
		endcase
	end

	always_comb begin
		use_unit = 1'b0;
		ureq.op = cfpb_pkg::U_MUL;
		src_a = cfpb_pkg::PROD_W'(cfpb_pkg::mag48(opa_q));
		src_b = (QW+1)'(cfpb_pkg::mag48(opb));
		neg_d = opa_q[QW-1] ^ opb[QW-1];
		unique case (uop.op)
			cfpb_pkg::OP_MAC, cfpb_pkg::OP_MSC: use_unit = 1'b1;
			cfpb_pkg::OP_SQ: begin
				use_unit = 1'b1;
				src_b = (QW+1)'(cfpb_pkg::mag48(opa_q));
			end
			cfpb_pkg::OP_SQRT: begin
				use_unit = 1'b1;
				ureq.op = cfpb_pkg::U_SQRT;
				src_a = sq_q;
			end
			cfpb_pkg::OP_DIVE: begin
				use_unit = !den_zero;
				ureq.op = cfpb_pkg::U_DIV;
				src_a = cfpb_pkg::PROD_W'(cfpb_pkg::mag48(opa_q)) << cfpb_pkg::FRAC_BITS;
				src_b = cfpb_pkg::mag49(den);
				neg_d = opa_q[QW-1] ^ den[QW];
			end
			cfpb_pkg::OP_DIVT: begin
				use_unit = 1'b1;
				ureq.op = cfpb_pkg::U_DIV;
				src_a = cfpb_pkg::PROD_W'(cfpb_pkg::mag48(opa_q)) << cfpb_pkg::FRAC_BITS;
				src_b = (QW+1)'(vthr_q);
				neg_d = opa_q[QW-1];
			end
			default: ;
		endcase
		ureq.start = use_unit && (state_q == cfpb_pkg::S_EXEC);
	end

	cfpb_unit u_unit (
		.clk(clk),
		.arst_n(arst_n),
		.req(ureq),
		.src_a(src_a),
		.src_b(src_b),
		.done(udone),
		.res(ures)
	);

	assign qres = cfpb_pkg::sat_mag(neg_q,
		(uop.op == cfpb_pkg::OP_MAC || uop.op == cfpb_pkg::OP_MSC)
			? (ures >> cfpb_pkg::FRAC_BITS) : ures);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfpb_pkg::S_IDLE: if (last_acc) state_d = cfpb_pkg::S_FETCH_A;
			cfpb_pkg::S_FETCH_A: state_d = cfpb_pkg::S_FETCH_B;
			cfpb_pkg::S_FETCH_B: state_d = cfpb_pkg::S_EXEC;
			cfpb_pkg::S_EXEC: begin
				if (use_unit)
					state_d = cfpb_pkg::S_WAIT;
				else if (uop.op == cfpb_pkg::OP_DONE)
					state_d = cfpb_pkg::S_OUT;
				else
					state_d = cfpb_pkg::S_FETCH_A;
			end
			cfpb_pkg::S_WAIT: if (udone) state_d = cfpb_pkg::S_FETCH_A;
			cfpb_pkg::S_OUT: if (out_free) state_d = cfpb_pkg::S_IDLE;
			default: state_d = cfpb_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		pc_next = pc_q;
		if (state_q == cfpb_pkg::S_IDLE)
			pc_next = '0;
		else if (state_q == cfpb_pkg::S_EXEC && !use_unit && uop.op != cfpb_pkg::OP_DONE)
			pc_next = (uop.op == cfpb_pkg::OP_JMP && jmp_taken) ? uop.tgt
				: pc_q + cfpb_pkg::PC_W'(1);
		else if (state_q == cfpb_pkg::S_WAIT && udone)
			pc_next = pc_q + cfpb_pkg::PC_W'(1);
		raddr = (state_q == cfpb_pkg::S_FETCH_B) ? uop.b[4:0] : uop.a[4:0];
		we = 1'b0;
		waddr = s_axis_tdata[4:0];
		wdata = s_axis_tdata[52:5];
		if (s_acc && s_axis_tdata[4:0] < 5'd24)
			we = 1'b1;
		else if (state_q == cfpb_pkg::S_EXEC && uop.op == cfpb_pkg::OP_ST) begin
			we = 1'b1;
			waddr = uop.a[4:0];
			wdata = st_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfpb_pkg::S_IDLE;
			pc_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_next;
			if (state_q == cfpb_pkg::S_OUT && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (last_acc)
			fault_q <= 1'b0;
		if (state_q == cfpb_pkg::S_FETCH_B)
			opa_q <= rdata_q;
		if (state_q == cfpb_pkg::S_EXEC) begin
			neg_q <= neg_d;
			unique case (uop.op)
				cfpb_pkg::OP_CLR: begin
					acc_q <= '0;
					sq_q <= '0;
				end
				cfpb_pkg::OP_LDA: acc_q <= sa;
				cfpb_pkg::OP_MAX0: if (acc_q < 0) acc_q <= '0;
				cfpb_pkg::OP_HERM: acc_q <= (sa <<< 1) + sa - (sb <<< 1);
				cfpb_pkg::OP_ONEM: acc_q <= cfpb_pkg::Q_ONE - sa;
				cfpb_pkg::OP_CLAMP: acc_q <= (cmin > lo_b) ? cmin : lo_b;
				cfpb_pkg::OP_DIVE: begin
					if (den_zero) begin
						fault_q <= 1'b1;
						if (opa_q > 0)
							acc_q <= AW'(cfpb_pkg::Q_MAX);
						else if (opa_q < 0)
							acc_q <= AW'(cfpb_pkg::Q_MIN);
						else
							acc_q <= '0;
					end
				end
				cfpb_pkg::OP_ST: begin
					if (uop.a == 6'd24) l0_q <= st_val;
					if (uop.a == 6'd12) l1_q <= st_val;
					if (uop.a == 6'd13) l2_q <= st_val;
				end
				default: ;
			endcase
		end
		if (state_q == cfpb_pkg::S_WAIT && udone) begin
			unique case (uop.op)
				cfpb_pkg::OP_MAC: acc_q <= acc_q + AW'(qres);
				cfpb_pkg::OP_MSC: acc_q <= acc_q - AW'(qres);
				cfpb_pkg::OP_DIVE, cfpb_pkg::OP_DIVT: acc_q <= AW'(qres);
				cfpb_pkg::OP_SQ: sq_q <= sq_q + ures;
				cfpb_pkg::OP_SQRT: begin
					acc_q <= AW'(cfpb_pkg::sat_mag(1'b0, ures));
					spd_lo_q <= cfpb_pkg::sat_mag(1'b0, ures) < QW'(cfpb_pkg::EPS_LSB);
					spd_hi_q <= cfpb_pkg::sat_mag(1'b0, ures) >= $signed(QW'(vthr_q));
				end
				default: ;
			endcase
		end
		if (state_q == cfpb_pkg::S_OUT && out_free) begin
			m_axis_tdata <= {l2_q, l1_q, l0_q};
			m_axis_tuser <= fault_q;
		end
	end

endmodule

// ===== design/cfpb_unit.sv =====
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide and square root.
// One bit (two radicand bits for the root) per cycle. Depends on cfpb_pkg.
module cfpb_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfpb_pkg::ureq_t               req,
	input  logic [cfpb_pkg::PROD_W-1:0]   src_a,
	input  logic [cfpb_pkg::Q_W:0]        src_b,
	output logic                          done,
	output logic [cfpb_pkg::PROD_W-1:0]   res
);

	logic busy_q;
	logic done_q;
	logic [cfpb_pkg::CNT_W-1:0] cnt_q;
	cfpb_pkg::unit_op_t op_q;
	logic [cfpb_pkg::PROD_W-1:0] w_q;
	logic [51:0] r_q;
	logic [cfpb_pkg::Q_W:0] m_q;
	logic [cfpb_pkg::Q_W-1:0] root_q;

	logic [cfpb_pkg::Q_W:0] msum;
	logic [cfpb_pkg::Q_W+1:0] dt;
	logic dge;
	logic [51:0] r4;
	logic [51:0] trial;
	logic sge;

	always_comb begin
		msum = {1'b0, w_q[cfpb_pkg::PROD_W-1:cfpb_pkg::Q_W]} + {1'b0, m_q[cfpb_pkg::Q_W-1:0]};
		dt = {r_q[cfpb_pkg::Q_W:0], w_q[cfpb_pkg::DIV_W-1]};
		dge = dt >= {1'b0, m_q};
		r4 = {r_q[49:0], w_q[cfpb_pkg::PROD_W-1:cfpb_pkg::PROD_W-2]};
		trial = 52'({root_q, 2'b01});
		sge = r4 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= cfpb_pkg::U_MUL;
		end else begin
			done_q <= busy_q && (cnt_q == cfpb_pkg::CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				cnt_q <= (req.op == cfpb_pkg::U_DIV) ? cfpb_pkg::CNT_W'(cfpb_pkg::DIV_W)
					: cfpb_pkg::CNT_W'(cfpb_pkg::Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - cfpb_pkg::CNT_W'(1);
				if (cnt_q == cfpb_pkg::CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			w_q <= src_a;
			m_q <= src_b;
			r_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				cfpb_pkg::U_MUL: begin
					if (w_q[0])
						w_q <= {msum, w_q[cfpb_pkg::Q_W-1:1]};
					else
						w_q <= {1'b0, w_q[cfpb_pkg::PROD_W-1:1]};
				end
				cfpb_pkg::U_DIV: begin
					r_q <= 52'(dge ? dt - {1'b0, m_q} : dt);
					w_q <= {w_q[cfpb_pkg::PROD_W-2:0], dge};
				end
				cfpb_pkg::U_SQRT: begin
					r_q <= sge ? r4 - trial : r4;
					root_q <= {root_q[cfpb_pkg::Q_W-2:0], sge};
					w_q <= {w_q[cfpb_pkg::PROD_W-3:0], 2'b00};
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		done = done_q;
		unique case (op_q)
			cfpb_pkg::U_MUL: res = w_q;
			cfpb_pkg::U_DIV: res = cfpb_pkg::PROD_W'(w_q[cfpb_pkg::DIV_W-1:0]);
			cfpb_pkg::U_SQRT: res = cfpb_pkg::PROD_W'(root_q);
			default: res = '0;
		endcase
	end

endmodule

// ===== design/cfpb_checker.sv =====
// Port-level checker for the contact friction block projection, with its bind statement.
// Depends only on the top level's ports.
module cfpb_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         s_axis_tlast,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("Result transaction dropped before it was taken.");

	a_normal_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[47])
		else $error("Normal impulse is negative.");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("Input ready during a sweep.");

	a_ready_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
		else $error("Input stalled after a plain operand transaction.");

endmodule

bind contact_friction_block_projection cfpb_checker u_cfpb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast(s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
